/* rtl/core/decimal_text_to_float32_unit_assert.svh */
// Assertion macros for the decimal text to float32 unit.
`ifndef DECIMAL_TEXT_TO_FLOAT32_UNIT_ASSERT_SVH
`define DECIMAL_TEXT_TO_FLOAT32_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DTF_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define DTF_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define DTF_ASSERT_IMPL(label, clk, rst_n, a, c)
`define DTF_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/core/dtf_pkg.sv */
// Shared types and constants for the decimal text to float32 unit.
`default_nettype none
package dtf_pkg;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [31:0] EXP_INF = 32'h7F80_0000;
	localparam int MANT_BITS = 23;
	localparam int EXP_BIAS = 127;

	// Finished string handed from the parser to the converter
	typedef struct packed {
		logic        bad;
		logic        negative;
		logic [63:0] int_acc;
		logic [63:0] frac_acc;
		logic [63:0] frac_den;
	} job_t;
endpackage
`default_nettype wire

/* rtl/core/dtf_front.sv */
// Character parser: accumulates digits and emits one job per string.
`default_nettype none
module dtf_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    ch,
	input  wire logic          has_char,
	input  wire logic          last,
	input  wire logic          in_valid,
	output logic               in_ready,
	output dtf_pkg::job_t      job,
	output logic               job_valid,
	input  wire logic          job_ready
);
	import dtf_pkg::*;

	typedef enum logic [1:0] {PH_START, PH_INT, PH_FRAC} phase_t;

	phase_t      phase_q;
	logic        neg_q, failed_q;
	logic [1:0]  count_q;
	logic [63:0] int_q, frac_q, den_q;

	logic        digit;
	logic [3:0]  d;
	logic [67:0] int10, frac10, den10;
	logic [68:0] int_n, frac_n;
	phase_t      ph_n;
	logic        neg_n, fail_n;
	logic [1:0]  cnt_n;
	logic [63:0] int_v, frac_v, den_v;
	logic        take;

	assign in_ready = !job_valid || job_ready;
	assign take = in_valid && in_ready;
	assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign d = ch[3:0];
	assign int10 = {4'd0, int_q} * 68'd10;
	assign frac10 = {4'd0, frac_q} * 68'd10;
	assign den10 = {4'd0, den_q} * 68'd10;
	assign int_n = {1'b0, int10} + {65'd0, d};
	assign frac_n = {1'b0, frac10} + {65'd0, d};

	// Apply one character to the state
	always_comb begin
		ph_n = phase_q; neg_n = neg_q; fail_n = failed_q; cnt_n = count_q;
		int_v = int_q; frac_v = frac_q; den_v = den_q;
		if (has_char) begin
			if (count_q != 2'd2) cnt_n = count_q + 2'd1;
			if (!failed_q) begin
				if (phase_q == PH_START && ch == CH_MINUS) begin
					ph_n = PH_INT; neg_n = 1'b1;
				end else if (phase_q != PH_FRAC) begin
					ph_n = PH_INT;
					if (ch == CH_POINT) ph_n = PH_FRAC;
					else if (!digit || int_n[68:64] != 5'd0) fail_n = 1'b1;
					else int_v = int_n[63:0];
				end else begin
					if (!digit || frac_n[68:64] != 5'd0 || den10[67:64] != 4'd0)
						fail_n = 1'b1;
					else begin
						frac_v = frac_n[63:0]; den_v = den10[63:0];
					end
				end
			end
		end
	end

	// Hold state, emit a job on last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START; neg_q <= 1'b0; failed_q <= 1'b0; count_q <= 2'd0;
			int_q <= '0; frac_q <= '0; den_q <= 64'd1; job_valid <= 1'b0;
		end else begin
			if (job_valid && job_ready && !(take && last)) job_valid <= 1'b0;
			if (take) begin
				if (last) begin
					job_valid <= 1'b1;
					job.bad <= fail_n || cnt_n == 2'd0 || (neg_n && cnt_n == 2'd1);
					job.negative <= neg_n;
					job.int_acc <= int_v;
					job.frac_acc <= frac_v;
					job.frac_den <= den_v;
					phase_q <= PH_START; neg_q <= 1'b0; failed_q <= 1'b0;
					count_q <= 2'd0; int_q <= '0; frac_q <= '0; den_q <= 64'd1;
				end else begin
					phase_q <= ph_n; neg_q <= neg_n; failed_q <= fail_n;
					count_q <= cnt_n; int_q <= int_v; frac_q <= frac_v; den_q <= den_v;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/core/dtf_back.sv */
// Converter: multiply, normalize, divide and round one job into float bits.
`default_nettype none
`include "decimal_text_to_float32_unit_assert.svh"
module dtf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  dtf_pkg::job_t      job,
	input  wire logic          job_valid,
	output logic               job_ready,
	output logic               res_ok,
	output logic [31:0]        res_bits,
	output logic               res_valid,
	input  wire logic          res_ready
);
	import dtf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_MULCHK, ST_NORM, ST_DIV, ST_ROUND, ST_OUT
	} state_t;

	state_t      state_q;
	logic        neg_q;
	logic [63:0] a_q, b_q, frac_q;
	logic [127:0] prod_q;
	logic [1:0]  part_q;
	logic [63:0] num_q, den_q, rem_q;
	logic signed [9:0] exp_q;
	logic [4:0]  step_q;
	logic [23:0] quo_q;

	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [64:0] sum;
	logic [64:0] r2;
	logic        qbit;
	logic [22:0] mant;
	logic        guard, sticky, up;
	logic [23:0] mant_r;
	logic signed [10:0] biased;

	assign job_ready = (state_q == ST_IDLE);
	assign pa = part_q[0] ? a_q[63:32] : a_q[31:0];
	assign pb = part_q[1] ? b_q[63:32] : b_q[31:0];
	assign pp = {32'd0, pa} * {32'd0, pb};
	assign sum = {1'b0, prod_q[63:0]} + {1'b0, frac_q};
	assign r2 = {rem_q, 1'b0};
	assign qbit = r2[64] || (r2[63:0] >= den_q);
	assign mant = quo_q[23:1];
	assign guard = quo_q[0];
	assign sticky = (rem_q != 64'd0);
	assign up = guard && (sticky || mant[0]);
	assign mant_r = {1'b0, mant} + {23'd0, up};
	assign biased = 11'(exp_q) + 11'(mant_r[23]) + 11'(EXP_BIAS);

	// Step through the conversion sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; res_valid <= 1'b0; part_q <= '0; step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) begin
					neg_q <= job.negative; a_q <= job.int_acc; b_q <= job.frac_den;
					frac_q <= job.frac_acc; den_q <= job.frac_den;
					prod_q <= '0; part_q <= 2'd0; exp_q <= '0;
					if (job.bad) begin
						res_ok <= 1'b0; res_bits <= '0; res_valid <= 1'b1; state_q <= ST_OUT;
					end else state_q <= ST_MUL;
				end
				ST_MUL: begin
					// accumulate one 32x32 partial product a cycle
					prod_q <= prod_q + ({64'd0, pp} << (7'(part_q[0]) * 7'd32
						+ 7'(part_q[1]) * 7'd32));
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) state_q <= ST_MULCHK;
				end
				ST_MULCHK: begin
					if (prod_q[127:64] != 64'd0 || sum[64]) begin
						res_ok <= 1'b0; res_bits <= '0; res_valid <= 1'b1; state_q <= ST_OUT;
					end else if (sum[63:0] == 64'd0) begin
						res_ok <= 1'b1; res_bits <= {neg_q, 31'd0}; res_valid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						num_q <= sum[63:0]; state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					// one shift a cycle until num/den lies in [1,2)
					if (num_q >= den_q) begin
						if (den_q <= (num_q >> 1)) begin
							den_q <= den_q << 1; exp_q <= exp_q + 10'sd1;
						end else begin
							rem_q <= num_q - den_q; step_q <= '0; state_q <= ST_DIV;
						end
					end else if (num_q[63]) begin
						res_ok <= 1'b0; res_bits <= '0; res_valid <= 1'b1; state_q <= ST_OUT;
					end else begin
						num_q <= num_q << 1; exp_q <= exp_q - 10'sd1;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					rem_q <= qbit ? (r2[63:0] - den_q) : r2[63:0];
					quo_q <= {quo_q[22:0], qbit};
					step_q <= step_q + 5'd1;
					if (step_q == 5'(MANT_BITS)) state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					res_ok <= 1'b1;
					if (biased >= 11'sd255) res_bits <= {neg_q, 31'd0} | EXP_INF;
					else if (biased <= 11'sd0) res_bits <= {neg_q, 31'd0};
					else res_bits <= {neg_q, biased[7:0], mant_r[22:0]};
					res_valid <= 1'b1; state_q <= ST_OUT;
				end
				ST_OUT: if (res_ready) begin
					res_valid <= 1'b0; state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`DTF_ASSERT_IMPL(a_valid_out, clk, arst_n, res_valid, state_q == ST_OUT)
	`DTF_ASSERT_IMPL(a_fail_zero, clk, arst_n, res_valid && !res_ok, res_bits == 32'd0)
	`DTF_ASSERT_NEXT(a_div_len, clk, arst_n, state_q == ST_DIV && step_q == 5'(MANT_BITS),
		state_q == ST_ROUND)
endmodule
`default_nettype wire

/* rtl/core/decimal_text_to_float32_unit.sv */
// Top level of the decimal text to float32 unit.
// Characters are taken one per cycle while the parser is ready; a string's end
// hands it to the converter, which captures it and then steps through its
// multiply, check, normalize shift, divide and rounding states before
// a number's result is offered.
// Bad strings are offered straight from capture, zeros and overflows from the check.
// The parser stalls its input while a finished job waits; a new job waits for
// the converter to go idle.
`default_nettype none
module decimal_text_to_float32_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata, // ch
	input  wire logic        s_tuser, // has_char
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata  // ok, float_bits, zero fill
);
	import dtf_pkg::*;

	job_t        job;
	logic        job_valid, job_ready, ok;
	logic [31:0] bits;

	dtf_front u_front (.clk, .arst_n, .ch(s_tdata), .has_char(s_tuser), .last(s_tlast),
		.in_valid(s_tvalid), .in_ready(s_tready), .job, .job_valid, .job_ready);
	dtf_back u_back (.clk, .arst_n, .job, .job_valid, .job_ready, .res_ok(ok),
		.res_bits(bits), .res_valid(m_tvalid), .res_ready(m_tready));

	assign m_tdata = {7'd0, bits, ok};
endmodule
`default_nettype wire
